>>> rtl/core/path_wildcard_matcher_unit_defines.svh
// Assertion macros shared by the path wildcard matcher RTL.
// Depends on nothing; taken in by the files that assert.
`ifndef PATH_WILDCARD_MATCHER_UNIT_DEFINES_SVH
`define PATH_WILDCARD_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("path wildcard matcher: assertion failed");

// Next-cycle implication, checked outside reset.
`define PWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("path wildcard matcher: assertion failed");

`endif

>>> rtl/core/pwm_pkg.sv
// Package for the path wildcard matcher: codes, constants and the token type
// that travels along the cell chain. Depends on nothing.
package pwm_pkg;

	localparam int PATTERN_MAX_DEF = 64;

	localparam logic [7:0] STAR_BYTE   = 8'h2A;
	localparam logic [7:0] DOLLAR_BYTE = 8'h24;

	// Input selector codes
	localparam logic [1:0] FUNC_PATTERN = 2'd0;
	localparam logic [1:0] FUNC_PATH    = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;

	typedef enum logic [1:0] {
		KIND_PATH,
		KIND_LOAD,
		KIND_QUERY
	} kind_t;

	// Token handed from cell to cell; carry and shift are the neighbour bits
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
		logic       wr_en;
		logic       anch;
		logic       qvalid;
		logic       qovf;
		logic [6:0] plen;
		logic       hit;
		logic       carry;
		logic       shift;
	} tok_t;

endpackage

>>> rtl/core/pwm_in_if.sv
// Input channel of the path wildcard matcher: valid/ready with one item.
// Depends on nothing.
interface pwm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output func, output data_byte, output last, input ready);
	modport sink   (input valid, input func, input data_byte, input last, output ready);
endinterface

>>> rtl/core/pwm_out_if.sv
// Result channel of the path wildcard matcher: valid/ready with one result.
// Depends on nothing.
interface pwm_out_if;
	logic       valid;
	logic       ready;
	logic       matched;
	logic [6:0] pattern_length;
	logic       pattern_overflow;

	modport source (output valid, output matched, output pattern_length,
		output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_length,
		input pattern_overflow, output ready);
endinterface

>>> rtl/core/pwm_front.sv
// Front control of the path wildcard matcher: load bookkeeping and token build.
// Depends on pwm_pkg and path_wildcard_matcher_unit_defines.svh.
`include "path_wildcard_matcher_unit_defines.svh"

module pwm_front #(
	parameter int PATTERN_MAX = pwm_pkg::PATTERN_MAX_DEF,
	localparam int CW = $clog2(PATTERN_MAX + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic          accept,
	input  logic [1:0]    func,
	input  logic [7:0]    data_byte,
	input  logic          last,
	output pwm_pkg::tok_t tok,
	output logic [CW-1:0] len,
	output logic [CW-1:0] widx
);

	localparam logic [CW-1:0] MAX_C = CW'(PATTERN_MAX);

	logic [CW-1:0] count_q;
	logic          load_done_q;
	logic          ovf_q;
	logic          dollar_q;

	logic          anch_cur;
	logic [CW-1:0] len_cur;
	logic [CW-1:0] cnt_base;
	logic          ovf_base;
	logic          we;
	logic [CW-1:0] cnt_next;
	logic          dollar_next;
	logic [CW-1:0] len_next;

	always_comb begin
		anch_cur    = (count_q != '0) && dollar_q;
		len_cur     = count_q - CW'(anch_cur);
		// a pattern byte after a finished load opens a new one
		cnt_base    = load_done_q ? '0 : count_q;
		ovf_base    = !load_done_q && ovf_q;
		we          = cnt_base < MAX_C;
		cnt_next    = we ? cnt_base + CW'(1) : cnt_base;
		dollar_next = we ? (data_byte == pwm_pkg::DOLLAR_BYTE) : dollar_q;
		len_next    = cnt_next - CW'(dollar_next);

		tok        = '0;
		tok.data   = data_byte;
		tok.anch   = anch_cur;
		tok.qvalid = load_done_q && !ovf_q && (count_q != '0);
		tok.qovf   = ovf_q;
		tok.plen   = 7'(count_q);
		len        = len_cur;
		widx       = cnt_base;

		unique case (func)
			pwm_pkg::FUNC_PATTERN: begin
				tok.valid = valid;
				tok.kind  = pwm_pkg::KIND_LOAD;
				tok.wr_en = we;
				len       = len_next;
			end
			pwm_pkg::FUNC_PATH: begin
				tok.valid = valid;
				tok.kind  = pwm_pkg::KIND_PATH;
			end
			pwm_pkg::FUNC_QUERY: begin
				tok.valid = valid;
				tok.kind  = pwm_pkg::KIND_QUERY;
			end
			default: begin
				tok.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			load_done_q <= 1'b0;
			ovf_q       <= 1'b0;
			dollar_q    <= 1'b0;
		end else if (accept && func == pwm_pkg::FUNC_PATTERN) begin
			count_q     <= cnt_next;
			load_done_q <= last;
			ovf_q       <= ovf_base || !we;
			dollar_q    <= dollar_next;
		end
	end

	`PWM_ASSERT_SAME(a_ovf_saturated, clk, arst_n, ovf_q, count_q == MAX_C)

endmodule

>>> rtl/core/pwm_cell.sv
// One position cell of the matcher chain: pattern byte, reach bit, end flag.
// Depends on pwm_pkg.
module pwm_cell #(
	parameter int PATTERN_MAX = pwm_pkg::PATTERN_MAX_DEF,
	parameter int POS = 0,
	localparam int CW = $clog2(PATTERN_MAX + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  pwm_pkg::tok_t tok_in,
	input  logic [CW-1:0] len_in,
	input  logic [CW-1:0] widx_in,
	output pwm_pkg::tok_t tok_out,
	output logic [CW-1:0] len_out,
	output logic [CW-1:0] widx_out
);

	localparam logic [CW-1:0] POS_C = CW'(POS);
	localparam logic          START = 1'(POS == 0);

	logic [7:0]    byte_q;
	logic          st_q;
	logic          end_q;
	pwm_pkg::tok_t tok_s1;
	logic [CW-1:0] len_s1;
	logic [CW-1:0] widx_s1;

	logic          wr_hit;
	logic [7:0]    byte_eff;
	logic          act;
	logic          at_len;
	logic          star;
	logic          is_path;
	logic          is_query;
	logic          st_new;
	logic          end_new;
	pwm_pkg::tok_t tok_nxt;

	always_comb begin
		wr_hit   = tok_in.valid && tok_in.kind == pwm_pkg::KIND_LOAD && tok_in.wr_en &&
			widx_in == POS_C;
		byte_eff = wr_hit ? tok_in.data : byte_q;
		act      = POS_C < len_in;
		at_len   = len_in == POS_C;
		star     = byte_eff == pwm_pkg::STAR_BYTE;
		is_path  = tok_in.kind == pwm_pkg::KIND_PATH;
		is_query = tok_in.kind == pwm_pkg::KIND_QUERY;

		// path byte: star self loop or literal shift; else restart at position zero
		st_new  = (is_path ? ((st_q && star && act) || tok_in.shift) : START) || tok_in.carry;
		end_new = is_path && (end_q || (st_new && at_len));

		tok_nxt       = tok_in;
		tok_nxt.carry = st_new && star && act;
		tok_nxt.shift = is_path && st_q && act && !star && (byte_eff == tok_in.data);
		if (is_query && at_len) begin
			tok_nxt.hit = tok_in.anch ? st_q : (st_q || end_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= START;
			end_q  <= 1'b0;
			tok_s1 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_nxt;
			if (tok_in.valid) begin
				st_q  <= st_new;
				end_q <= end_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s1  <= len_in;
			widx_s1 <= widx_in;
			if (wr_hit) begin
				byte_q <= tok_in.data;
			end
		end
	end

	assign tok_out  = tok_s1;
	assign len_out  = len_s1;
	assign widx_out = widx_s1;

endmodule

>>> rtl/core/path_wildcard_matcher_unit.sv
// Top level of the path wildcard matcher: front control, cell chain, result register.
// Depends on pwm_pkg, pwm_in_if, pwm_out_if, pwm_front, pwm_cell and the defines header.
//
//   channel  | modport | beat contents
//   ---------+---------+---------------------------------------------------
//   item     | sink    | func, data_byte, last
//   result   | source  | matched, pattern_length, pattern_overflow
//
// One item is taken every cycle unless the chain halts. Every item walks the chain
// of PATTERN_MAX + 1 position cells, one cell a cycle while it advances, and a query
// moves from the chain end into the result register. The chain halts, and item.ready
// drops, only while a query sits at the chain end and the result register holds an
// untaken beat. Reset clears control state; pattern bytes stay undefined until loaded.
`include "path_wildcard_matcher_unit_defines.svh"

module path_wildcard_matcher_unit #(
	parameter int PATTERN_MAX = pwm_pkg::PATTERN_MAX_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pwm_in_if.sink    item,
	pwm_out_if.source result
);

	localparam int CW = $clog2(PATTERN_MAX + 1);

	// Chain links: entry g feeds cell g, the extra entry is the chain end
	pwm_pkg::tok_t chain_tok  [0:PATTERN_MAX+1];
	logic [CW-1:0] chain_len  [0:PATTERN_MAX];
	logic [CW-1:0] chain_widx [0:PATTERN_MAX];

	pwm_pkg::tok_t tail;
	logic          tail_query;
	logic          stall;
	logic          adv;

	logic          out_valid_q;
	logic          matched_q;
	logic [6:0]    plen_q;
	logic          povf_q;

	assign tail       = chain_tok[PATTERN_MAX+1];
	assign tail_query = tail.valid && tail.kind == pwm_pkg::KIND_QUERY;
	// hold the whole chain while a finished query cannot move into the result register
	assign stall      = tail_query && out_valid_q && !result.ready;
	assign adv        = !stall;
	assign item.ready = adv;

	pwm_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (item.valid),
		.accept   (item.valid && item.ready),
		.func     (item.func),
		.data_byte(item.data_byte),
		.last     (item.last),
		.tok      (chain_tok[0]),
		.len      (chain_len[0]),
		.widx     (chain_widx[0])
	);

	// One cell per pattern position, plus one for the position after the last byte
	for (genvar g = 0; g <= PATTERN_MAX; g++) begin : g_cell
		if (g < PATTERN_MAX) begin : g_mid
			pwm_cell #(
				.PATTERN_MAX(PATTERN_MAX),
				.POS        (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.tok_in  (chain_tok[g]),
				.len_in  (chain_len[g]),
				.widx_in (chain_widx[g]),
				.tok_out (chain_tok[g+1]),
				.len_out (chain_len[g+1]),
				.widx_out(chain_widx[g+1])
			);
		end else begin : g_end
			pwm_cell #(
				.PATTERN_MAX(PATTERN_MAX),
				.POS        (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.tok_in  (chain_tok[g]),
				.len_in  (chain_len[g]),
				.widx_in (chain_widx[g]),
				.tok_out (chain_tok[g+1]),
				.len_out (),
				.widx_out()
			);
		end
	end

	// Result register: load a finished query, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && tail_query) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail_query) begin
			matched_q <= tail.qvalid && tail.hit;
			plen_q    <= tail.plen;
			povf_q    <= tail.qovf;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.matched          = matched_q;
	assign result.pattern_length   = plen_q;
	assign result.pattern_overflow = povf_q;

	`PWM_ASSERT_NEXT(a_query_lands, clk, arst_n, adv && tail_query, out_valid_q)
	`PWM_ASSERT_SAME(a_ovf_no_match, clk, arst_n, out_valid_q && matched_q, !povf_q)
	`PWM_ASSERT_NEXT(a_stall_holds, clk, arst_n, stall, $stable(tail))

endmodule

>>> tb/sv/pwm_verdict_checker.sv
// Verdict checker for the path wildcard matcher: watches the item and result
// channels, predicts every query's verdict and compares it with the result beats.
// Depends on pwm_pkg, pwm_in_if and pwm_out_if.
`timescale 1ns / 1ps

module pwm_verdict_checker #(
	parameter int PATTERN_MAX = pwm_pkg::PATTERN_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pwm_in_if    item_mon,
	pwm_out_if   rslt_mon,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic       matched;
		logic [6:0] plen;
		logic       ovf;
	} verdict_t;

	logic [7:0]         rule_mem [PATTERN_MAX];
	int unsigned        rule_len;
	bit                 rule_closed;
	bit                 rule_ovf;
	bit [PATTERN_MAX:0] reach;        // bit p: the path so far can have used p rule bytes
	bit                 tail_seen;    // whole unanchored body matched at some point
	verdict_t           expected_verdicts [$];
	int                 errs;

	initial begin
		rule_len    = 0;
		rule_closed = 1'b0;
		rule_ovf    = 1'b0;
		reach       = {{PATTERN_MAX{1'b0}}, 1'b1};
		tail_seen   = 1'b0;
		errs        = 0;
	end

	function automatic bit rule_anchored();
		return rule_len != 0 && rule_mem[rule_len - 1] == pwm_pkg::DOLLAR_BYTE;
	endfunction

	function automatic int unsigned body_len();
		return rule_anchored() ? rule_len - 1 : rule_len;
	endfunction

	function automatic void restart_path();
		reach     = {{PATTERN_MAX{1'b0}}, 1'b1};
		tail_seen = 1'b0;
	endfunction

	// A reachable star also reaches the next position (empty run); walk upwards
	// so that runs of stars close in one pass.
	function automatic void close_stars(int unsigned len);
		for (int unsigned p = 0; p < len; p++)
			if (reach[p] && rule_mem[p] == pwm_pkg::STAR_BYTE)
				reach[p + 1] = 1'b1;
	endfunction

	function automatic void take_rule_byte(logic [7:0] b, logic lst);
		if (rule_closed) begin
			rule_len    = 0;
			rule_ovf    = 1'b0;
			rule_closed = 1'b0;
		end
		if (rule_len < PATTERN_MAX) begin
			rule_mem[rule_len] = b;
			rule_len++;
		end else begin
			rule_ovf = 1'b1;
		end
		if (lst)
			rule_closed = 1'b1;
		restart_path();
	endfunction

	function automatic void advance_path(logic [7:0] c);
		bit [PATTERN_MAX:0] nxt;
		int unsigned        len;
		len = body_len();
		nxt = '0;
		close_stars(len);
		for (int unsigned p = 0; p < len; p++) begin
			if (reach[p]) begin
				if (rule_mem[p] == pwm_pkg::STAR_BYTE)
					nxt[p] = 1'b1;
				else if (rule_mem[p] == c)
					nxt[p + 1] = 1'b1;
			end
		end
		reach = nxt;
		close_stars(len);
		if (reach[len])
			tail_seen = 1'b1;
	endfunction

	function automatic verdict_t answer_query();
		verdict_t    v;
		int unsigned len;
		bit          hit;
		len = body_len();
		close_stars(len);
		hit = rule_anchored() ? reach[len] : (tail_seen || reach[len]);
		v.matched = rule_closed && !rule_ovf && rule_len != 0 && hit;
		v.plen    = rule_len[6:0];
		v.ovf     = rule_ovf;
		restart_path();
		return v;
	endfunction

	// Compare result beats before taking this edge's item beat: a query never
	// answers in the cycle it is taken.
	always @(posedge clk) begin : watch
		verdict_t want;
		if (arst_n) begin
			if (rslt_mon.valid && rslt_mon.ready) begin
				if (expected_verdicts.size() == 0) begin
					errs++;
					$display("%0t ns: unexpected result beat, ", $time,
						"got matched=%0b length=%0d overflow=%0b",
						rslt_mon.matched, rslt_mon.pattern_length,
						rslt_mon.pattern_overflow);
				end else begin
					want = expected_verdicts.pop_front();
					if (rslt_mon.matched !== want.matched
							|| rslt_mon.pattern_length !== want.plen
							|| rslt_mon.pattern_overflow !== want.ovf) begin
						errs++;
						$display("%0t ns: verdict mismatch, ", $time,
							"expected matched=%0b length=%0d overflow=%0b, ",
							want.matched, want.plen, want.ovf,
							"got matched=%0b length=%0d overflow=%0b",
							rslt_mon.matched, rslt_mon.pattern_length,
							rslt_mon.pattern_overflow);
					end
				end
			end
			if (item_mon.valid && item_mon.ready) begin
				case (item_mon.func)
					pwm_pkg::FUNC_PATTERN: take_rule_byte(item_mon.data_byte, item_mon.last);
					pwm_pkg::FUNC_PATH:    advance_path(item_mon.data_byte);
					pwm_pkg::FUNC_QUERY:   expected_verdicts.push_back(answer_query());
					default:               ;
				endcase
			end
		end
		fail_count <= errs;
		pending    <= expected_verdicts.size();
	end

endmodule

>>> tb/sv/tb_path_wildcard_matcher_unit.sv
// Top of the path wildcard matcher testbench: clock, reset, item and result
// stimulus, and the final verdict. Depends on pwm_pkg, the channel interfaces,
// path_wildcard_matcher_unit and pwm_verdict_checker.
`timescale 1ns / 1ps

module tb_path_wildcard_matcher_unit;

	localparam int          PATTERN_MAX  = pwm_pkg::PATTERN_MAX_DEF;
	localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
	localparam logic [7:0]  CHAR_A       = 8'h61;
	localparam logic [7:0]  CHAR_B       = 8'h62;
	localparam int unsigned RANDOM_ITEMS = 1600;
	localparam int unsigned STALL_AFTER  = 700;   // beats sent before the long hold-off
	localparam int unsigned STALL_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          pending;
	int unsigned beats_sent;
	bit          hold_rx;
	bit          tx_calm;
	logic [7:0]  rule_copy [$];   // last rule sent, used to steer paths towards hits

	pwm_in_if  item_ch();
	pwm_out_if rslt_ch();

	path_wildcard_matcher_unit #(.PATTERN_MAX(PATTERN_MAX)) uut (
		.clk,
		.arst_n,
		.item   (item_ch),
		.result (rslt_ch)
	);

	pwm_verdict_checker #(.PATTERN_MAX(PATTERN_MAX)) u_verdict (
		.clk,
		.arst_n,
		.item_mon   (item_ch),
		.rslt_mon   (rslt_ch),
		.fail_count,
		.pending
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#2_000_000;
		$display("tb_path_wildcard_matcher_unit: FAIL");
		$finish;
	end

	// Result side: after each beat draw a random idle gap, with calm stretches of
	// no gaps at all. Hold ready low while the long stall runs.
	initial begin : rx_side
		int unsigned gap;
		bit          calm;
		gap  = 0;
		calm = 1'b0;
		rslt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rslt_ch.valid && rslt_ch.ready) begin
				if ($urandom_range(0, 29) == 0)
					calm = !calm;
				gap = calm ? 0 : $urandom_range(0, 6);
			end else if (gap != 0) begin
				gap--;
			end
			rslt_ch.ready <= (gap == 0) && !hold_rx && arst_n;
		end
	end

	// Long hold-off on the result side once the stream is well under way: the
	// chain fills with queries and the block must stall its item input.
	initial begin : rx_hold
		hold_rx <= 1'b0;
		while (beats_sent < STALL_AFTER)
			@(posedge clk);
		hold_rx <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Offer one beat after a random gap and hold it until taken. Keep valid high
	// across back-to-back beats so it is never dropped and raised in one step.
	task automatic send_beat(logic [1:0] f, logic [7:0] b, logic lst);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.func      <= f;
		item_ch.data_byte <= b;
		item_ch.last      <= lst;
		do @(posedge clk); while (!item_ch.ready);
		if (f != FUNC_UNUSED)
			beats_sent++;
	endtask

	// Rule bytes lean on a small alphabet so that stars and literals interact.
	function automatic logic [7:0] pick_rule_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) return CHAR_A;
		if (r < 60) return CHAR_B;
		if (r < 85) return pwm_pkg::STAR_BYTE;
		if (r < 90) return pwm_pkg::DOLLAR_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_path_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return CHAR_A;
		if (r < 80) return CHAR_B;
		return 8'($urandom_range(0, 255));
	endfunction

	// Send a rule of len bytes; end it with a dollar when anchored, and mark the
	// final byte as last only when the load is to be closed.
	task automatic load_rule(int unsigned len, bit anchored, bit closed);
		logic [7:0] b;
		rule_copy.delete();
		for (int unsigned i = 0; i < len; i++) begin
			b = (anchored && i == len - 1) ? pwm_pkg::DOLLAR_BYTE : pick_rule_byte();
			rule_copy.push_back(b);
			send_beat(pwm_pkg::FUNC_PATTERN, b, closed && i == len - 1);
		end
	endtask

	// Send one path followed by its query. Most paths follow the rule (literals
	// as they stand, a random run for each star), some with a byte spoilt or a
	// tail added; the rest are plain random paths.
	task automatic probe_path();
		logic [7:0]  walk [$];
		int unsigned body;
		body = rule_copy.size();
		if (body != 0 && rule_copy[body - 1] == pwm_pkg::DOLLAR_BYTE)
			body--;
		if ($urandom_range(0, 2) != 0) begin
			for (int unsigned i = 0; i < body; i++) begin
				if (rule_copy[i] == pwm_pkg::STAR_BYTE)
					repeat ($urandom_range(0, 3)) walk.push_back(pick_path_byte());
				else
					walk.push_back(rule_copy[i]);
			end
			if ($urandom_range(0, 3) == 0 && walk.size() != 0)
				walk[$urandom_range(0, walk.size() - 1)] = pick_path_byte();
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) walk.push_back(pick_path_byte());
		end else begin
			repeat ($urandom_range(0, 12)) walk.push_back(pick_path_byte());
		end
		// The last flag means nothing on path bytes or queries: toggle it freely.
		foreach (walk[i])
			send_beat(pwm_pkg::FUNC_PATH, walk[i], 1'($urandom_range(0, 1)));
		send_beat(pwm_pkg::FUNC_QUERY, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		int unsigned roll;
		int unsigned len;
		beats_sent = 0;
		tx_calm    = 1'b0;
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.func      <= pwm_pkg::FUNC_PATTERN;
		item_ch.data_byte <= 8'h00;
		item_ch.last      <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Query with nothing loaded: empty rule, no match.
		send_beat(pwm_pkg::FUNC_QUERY, 8'h00, 1'b0);
		// Open load: the query must not match, and last on a query is ignored.
		send_beat(pwm_pkg::FUNC_PATTERN, 8'h00, 1'b0);
		send_beat(pwm_pkg::FUNC_QUERY, 8'hFF, 1'b1);
		// Close the load with an all-ones byte; the path hits as a prefix.
		send_beat(pwm_pkg::FUNC_PATTERN, 8'hFF, 1'b1);
		send_beat(pwm_pkg::FUNC_PATH, 8'h00, 1'b1);
		send_beat(pwm_pkg::FUNC_PATH, 8'hFF, 1'b0);
		send_beat(pwm_pkg::FUNC_QUERY, 8'h00, 1'b0);
		// Unused selector: dropped, no result.
		send_beat(FUNC_UNUSED, 8'hFF, 1'b1);
		// Anchored rule whose last segment also turns up earlier in the path:
		// true glob semantics must still match.
		send_beat(pwm_pkg::FUNC_PATTERN, pwm_pkg::STAR_BYTE, 1'b0);
		send_beat(pwm_pkg::FUNC_PATTERN, CHAR_B, 1'b0);
		send_beat(pwm_pkg::FUNC_PATTERN, pwm_pkg::DOLLAR_BYTE, 1'b1);
		send_beat(pwm_pkg::FUNC_PATH, CHAR_B, 1'b0);
		send_beat(pwm_pkg::FUNC_PATH, CHAR_A, 1'b0);
		send_beat(pwm_pkg::FUNC_PATH, CHAR_B, 1'b0);
		send_beat(pwm_pkg::FUNC_QUERY, 8'h00, 1'b0);
		// Lone dollar: matches the empty path only.
		send_beat(pwm_pkg::FUNC_PATTERN, pwm_pkg::DOLLAR_BYTE, 1'b1);
		send_beat(pwm_pkg::FUNC_QUERY, 8'h00, 1'b0);
		send_beat(pwm_pkg::FUNC_PATH, CHAR_A, 1'b0);
		send_beat(pwm_pkg::FUNC_QUERY, 8'h00, 1'b0);

		// Random part: rules of mixed size, a few overlong or left open, each
		// probed by several paths with some noise in between.
		while (beats_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 6)
				len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 6);
			else if (roll < 10)
				len = $urandom_range(PATTERN_MAX / 2, PATTERN_MAX);
			else
				len = $urandom_range(1, 8);
			load_rule(len, $urandom_range(0, 2) == 0, $urandom_range(0, 19) != 0);
			repeat ($urandom_range(1, 6)) begin
				roll = $urandom_range(0, 99);
				if (roll < 5)
					send_beat(FUNC_UNUSED, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				else if (roll < 8)
					send_beat(pwm_pkg::FUNC_PATTERN, pick_rule_byte(),
						1'($urandom_range(0, 1)));
				probe_path();
			end
		end
		item_ch.valid <= 1'b0;

		// Let the checker see the final beat, then drain all expected results.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PATTERN_MAX + 8) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_path_wildcard_matcher_unit: PASS");
		else
			$display("tb_path_wildcard_matcher_unit: FAIL");
		$finish;
	end

endmodule

>>> path_wildcard_matcher_unit.f
+incdir+rtl/core
rtl/core/pwm_pkg.sv
rtl/core/pwm_in_if.sv
rtl/core/pwm_out_if.sv
rtl/core/pwm_front.sv
rtl/core/pwm_cell.sv
rtl/core/path_wildcard_matcher_unit.sv
tb/sv/pwm_verdict_checker.sv
tb/sv/tb_path_wildcard_matcher_unit.sv
